/* hdl/ntru_dc_pkg.sv */
// Package for the NTRU decryption convolution block: item kinds, register
// indexes, field widths and default register values.
// No dependencies; every other file imports it.
package ntru_dc_pkg;

  localparam int KIND_W  = 3;
  localparam int INDEX_W = 10;
  localparam int COEFF_W = 17;
  localparam int RING_W  = 11;
  localparam int MOD_W   = 17;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam int MAX_RING_DEF = 1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_KEY    = 3'd0,
    KIND_LOAD_INV    = 3'd1,
    KIND_LOAD_CIPHER = 3'd2,
    KIND_START       = 3'd3,
    KIND_READ        = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_RING_SIZE     = 2'd0,
    REG_LARGE_MODULUS = 2'd1,
    REG_SMALL_MODULUS = 2'd2
  } reg_idx_t;

  localparam logic [RING_W-1:0] RING_SIZE_RST     = 11'd251;
  localparam logic [MOD_W-1:0]  LARGE_MODULUS_RST = 17'd2048;
  localparam logic [MOD_W-1:0]  SMALL_MODULUS_RST = 17'd3;

endpackage

/* hdl/ntru_dc_if.sv */
// Valid/ready channel interfaces for the NTRU decryption convolution block.
// Depends on ntru_dc_pkg for the field widths.
interface ntru_dc_in_if;
  import ntru_dc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [INDEX_W-1:0]         coeff_index;
  logic signed [COEFF_W-1:0]  coeff_value;
  modport source (output valid, kind, coeff_index, coeff_value, input ready);
  modport sink (input valid, kind, coeff_index, coeff_value, output ready);
endinterface

interface ntru_dc_out_if;
  import ntru_dc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COEFF_W-1:0]  read_value;
  logic                       status;
  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

/* hdl/ntru_decrypt_convolution_top.sv */
// Top level of the NTRU decryption convolution block: coefficient stores,
// convolution sequencer, multiply-accumulate and a bit-serial modulo unit.
// Depends on ntru_dc_pkg and the channel interfaces in ntru_dc_if.sv.
//
//   channel   direction  handshake            payload
//   in_ch     in         valid/ready          kind, coeff_index, coeff_value
//   out_ch    out        valid/ready          read_value, status
//   APB       in         psel/penable/pready  paddr, pwdata, prdata
//
// Load items and unused kinds are answered as soon as they are taken, read
// items after the S_READ state (the message store has a registered read). A
// start item answers at once and then keeps the block busy for two
// convolutions, each coefficient of the first reduced by the large and then
// the small modulus, paced by the single multiplier, the pipeline drain and
// the one-bit-a-cycle modulo unit. After reset the message store is cleared
// one entry a cycle, during which no item is taken.
// The input is taken only in the idle state while the result register is
// empty or being emptied, so a stalled output holds the input off.
module ntru_decrypt_convolution_top #(
  parameter int MAX_RING = ntru_dc_pkg::MAX_RING_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ntru_dc_in_if.sink                          in_ch,
  ntru_dc_out_if.source                       out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ntru_dc_pkg::CFG_AW-1:0]      paddr,
  input  logic [ntru_dc_pkg::CFG_DW-1:0]      pwdata,
  output logic [ntru_dc_pkg::CFG_DW-1:0]      prdata,
  output logic                                pready
);
  import ntru_dc_pkg::*;

  localparam int AW    = $clog2(MAX_RING);
  localparam int NW    = $clog2(MAX_RING + 1);
  localparam int ACC_W = 35 + AW;
  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam logic [15:0] MAX16 = 16'(MAX_RING);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CONV  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [RING_W-1:0] ring_size_r;
  logic [MOD_W-1:0]  large_mod_r;
  logic [MOD_W-1:0]  small_mod_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
      large_mod_r <= LARGE_MODULUS_RST;
      small_mod_r <= SMALL_MODULUS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RING_SIZE:     ring_size_r <= pwdata[RING_W-1:0];
        REG_LARGE_MODULUS: large_mod_r <= pwdata[MOD_W-1:0];
        REG_SMALL_MODULUS: small_mod_r <= pwdata[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RING_SIZE:     prdata = CFG_DW'(ring_size_r);
      REG_LARGE_MODULUS: prdata = CFG_DW'(large_mod_r);
      REG_SMALL_MODULUS: prdata = CFG_DW'(small_mod_r);
      default:           prdata = '0;
    endcase
  end

  // Effective ring size and index check.
  logic [15:0]   ring16;
  logic [NW-1:0] n_eff;
  logic [AW-1:0] n_m1;
  logic [15:0]   idx16;
  logic          idx_ok;
  logic [AW-1:0] in_addr;

  assign ring16  = 16'(ring_size_r);
  assign n_eff   = (ring16 >= MAX16) ? NW'(MAX_RING) : NW'(ring16);
  assign n_m1    = AW'(n_eff - NW'(1));
  assign idx16   = 16'(in_ch.coeff_index);
  assign idx_ok  = idx16 < 16'(n_eff);
  assign in_addr = AW'(idx16);

  // Handshakes and output register.
  logic                      in_acc;
  logic                      out_valid_r;
  logic signed [COEFF_W-1:0] out_value_r;
  logic                      out_status_r;
  logic                      kind_load;

  assign in_ch.ready      = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.status    = out_status_r;
  assign kind_load = (in_ch.kind == KIND_LOAD_KEY) || (in_ch.kind == KIND_LOAD_INV) ||
                     (in_ch.kind == KIND_LOAD_CIPHER);

  // Sequencer counters and datapath registers.
  logic [AW-1:0]             clr_r, k_r, i_r, j_r;
  logic                      pass_r, stage_r;
  logic                      v1_r, v2_r;
  logic signed [33:0]        prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]          mag_r;
  logic [MOD_W-1:0]          rem_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r;

  // Memories.
  logic signed [COEFF_W-1:0] key_mem    [MAX_RING];
  logic signed [COEFF_W-1:0] inv_mem    [MAX_RING];
  logic signed [COEFF_W-1:0] cipher_mem [MAX_RING];
  logic signed [COEFF_W-1:0] mid_mem    [MAX_RING];
  logic signed [COEFF_W-1:0] msg_mem    [MAX_RING];
  logic signed [COEFF_W-1:0] key_q, inv_q, cipher_q, mid_q, msg_q;
  logic signed [COEFF_W-1:0] x_q, y_q;

  // Modulo unit: finishing step of the remainder and its centering.
  logic [MOD_W-1:0]          mod_sel;
  logic [MOD_W:0]            rem_fix;
  logic signed [MOD_W:0]     cen;
  logic signed [COEFF_W-1:0] res;
  logic [MOD_W:0]            rem2, rem2_sub;
  logic                      div_done, drain_done, reload, store;
  logic signed [ACC_W-1:0]   ld_val;

  assign mod_sel  = (!pass_r && !stage_r) ? large_mod_r : small_mod_r;
  assign rem_fix  = (neg_r && rem_r != '0) ? ({1'b0, mod_sel} - {1'b0, rem_r})
                                           : {1'b0, rem_r};
  assign cen      = (rem_fix > {2'b0, mod_sel[MOD_W-1:1]})
                    ? $signed(rem_fix - {1'b0, mod_sel}) : $signed(rem_fix);
  assign res      = (mod_sel == '0) ? '0 : cen[COEFF_W-1:0];
  assign rem2     = {rem_r, mag_r[ACC_W-1]};
  assign rem2_sub = (rem2 >= {1'b0, mod_sel}) ? rem2 - {1'b0, mod_sel} : rem2;
  assign div_done   = (state_r == S_DIV) && (cnt_r == '0);
  assign drain_done = (state_r == S_DRAIN) && !v1_r && !v2_r;
  assign reload     = div_done && !pass_r && !stage_r;
  assign store      = div_done && !reload;
  assign ld_val     = drain_done ? acc_r : ACC_W'(res);

  assign x_q = pass_r ? inv_q : key_q;
  assign y_q = pass_r ? mid_q : cipher_q;

  always_ff @(posedge clk) begin
    if (in_acc && kind_load && idx_ok) begin
      case (in_ch.kind)
        KIND_LOAD_KEY:    key_mem[in_addr]    <= in_ch.coeff_value;
        KIND_LOAD_INV:    inv_mem[in_addr]    <= in_ch.coeff_value;
        KIND_LOAD_CIPHER: cipher_mem[in_addr] <= in_ch.coeff_value;
        default: ;
      endcase
    end
    if (store && !pass_r) mid_mem[k_r] <= res;
    if (state_r == S_CLEAR) msg_mem[clr_r] <= '0;
    else if (store && pass_r) msg_mem[k_r] <= res;
    key_q    <= key_mem[i_r];
    inv_q    <= inv_mem[i_r];
    cipher_q <= cipher_mem[j_r];
    mid_q    <= mid_mem[j_r];
    msg_q    <= msg_mem[in_addr];
  end

  // State sequencing.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(MAX_RING - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc && in_ch.kind == KIND_READ && idx_ok) state_nxt = S_READ;
        else if (in_acc && in_ch.kind == KIND_START && n_eff != '0) state_nxt = S_CONV;
      end
      S_READ:  state_nxt = S_IDLE;
      S_CONV:  if (i_r == n_m1) state_nxt = S_DRAIN;
      S_DRAIN: if (drain_done) state_nxt = S_DIV;
      S_DIV: begin
        if (store) begin
          if (k_r != n_m1) state_nxt = S_CONV;
          else if (!pass_r) state_nxt = S_CONV;
          else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pass_r      <= 1'b0;
      stage_r     <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);

      // Result register: a new item result replaces one being taken.
      if (state_r == S_READ) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= msg_q;
        out_status_r <= 1'b0;
      end else if (in_acc && !(in_ch.kind == KIND_READ && idx_ok)) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= '0;
        out_status_r <= (kind_load || in_ch.kind == KIND_READ) && !idx_ok;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // Start: first pass, first output coefficient.
      if (state_r == S_IDLE && state_nxt == S_CONV) begin
        pass_r  <= 1'b0;
        stage_r <= 1'b0;
        k_r     <= '0;
        i_r     <= '0;
        j_r     <= '0;
        acc_r   <= '0;
      end

      // Read address walk: i runs up, j = (k - i) mod N runs down with wrap.
      if (state_r == S_CONV) begin
        i_r <= i_r + AW'(1);
        j_r <= (j_r == '0) ? n_m1 : j_r - AW'(1);
      end
      v1_r   <= (state_r == S_CONV);
      v2_r   <= v1_r;
      prod_r <= x_q * y_q;
      if (v2_r) acc_r <= acc_r + ACC_W'(prod_r);

      // Load the modulo unit with the magnitude and sign of its operand.
      if (drain_done || reload) begin
        mag_r   <= ld_val[ACC_W-1] ? ACC_W'(-ld_val) : ACC_W'(ld_val);
        neg_r   <= ld_val[ACC_W-1];
        rem_r   <= '0;
        cnt_r   <= CNT_W'(ACC_W);
        stage_r <= reload;
      end else if (state_r == S_DIV && cnt_r != '0) begin
        rem_r <= rem2_sub[MOD_W-1:0];
        mag_r <= {mag_r[ACC_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
      end

      // Coefficient written back: move to the next one or the next pass.
      if (store) begin
        stage_r <= 1'b0;
        acc_r   <= '0;
        i_r     <= '0;
        if (k_r != n_m1) begin
          k_r <= k_r + AW'(1);
          j_r <= k_r + AW'(1);
        end else begin
          pass_r <= 1'b1;
          k_r    <= '0;
          j_r    <= '0;
        end
      end
    end
  end

endmodule
